// File: design/pei_pkg.sv
package pei_pkg;

  // Fixed word of the payload fields: signed Q16.16 by default
  localparam int WORD_BITS      = 32;
  localparam int PEI_FRAC_BITS  = 16;
  localparam int STEP_BITS      = 17;
  localparam int PROD_BITS      = 2 * WORD_BITS + 1;
  localparam int CFG_IDX_BITS   = 3;
  localparam int AXES           = 3;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_ADD_FORCE = 2'd0,
    KIND_UPDATE    = 2'd1,
    KIND_SET_POS   = 2'd2,
    KIND_SET_VEL   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INV_MASS = 3'd0,
    CFG_MIN_X    = 3'd1,
    CFG_MIN_Y    = 3'd2,
    CFG_MIN_Z    = 3'd3,
    CFG_MAX_X    = 3'd4,
    CFG_MAX_Y    = 3'd5,
    CFG_MAX_Z    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    kind_t                  kind;
    logic signed [31:0]     vec_x;
    logic signed [31:0]     vec_y;
    logic signed [31:0]     vec_z;
    logic [STEP_BITS-1:0]   step_time;
  } pei_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } pei_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture an input beat
    logic mul_acc;  // product = force * inverse_mass
    logic mul_dv;   // product = accel * dt
    logic add_v;    // new velocity = velocity + dv
    logic mul_dp;   // product = new velocity * dt
    logic commit;   // write stores and result register
  } pei_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_update;  // incoming beat is an update step
  } pei_stat_t;

  // Signed add, saturated to the word range
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

endpackage

// File: design/pei_ctrl.sv
module pei_ctrl import pei_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pei_stat_t stat,
  output pei_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MUL_ACC = 6'b000010,
    ST_MUL_DV  = 6'b000100,
    ST_ADD_V   = 6'b001000,
    ST_MUL_DP  = 6'b010000,
    ST_COMMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequence one item through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = stat.in_update ? ST_MUL_ACC : ST_COMMIT;
        end
      end
      ST_MUL_ACC: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = ST_MUL_DV;
      end
      ST_MUL_DV: begin
        cmd.mul_dv = 1'b1;
        state_nxt  = ST_ADD_V;
      end
      ST_ADD_V: begin
        cmd.add_v = 1'b1;
        state_nxt = ST_MUL_DP;
      end
      ST_MUL_DP: begin
        cmd.mul_dp = 1'b1;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register is free
        cmd.commit = !out_valid_r || out_ready;
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit into an occupied result register");

  a_update_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.in_update) |=> state_r == ST_MUL_ACC)
    else $error("update beat did not start the multiply sequence");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_COMMIT))
    else $error("result appeared without a commit");
`endif

endmodule

// File: design/pei_dpath.sv
module pei_dpath import pei_pkg::*; #(
  parameter int FRAC_BITS = PEI_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pei_in_t                 in_item,
  output pei_out_t                out_item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_wdata,
  input  pei_cmd_t                cmd,
  output pei_stat_t               stat
);

  // Floor of product / 2^FRAC_BITS, saturated to the word range
  function automatic word_t sat_prod(input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] sh;
    sh = p >>> FRAC_BITS;
    if ((&sh[PROD_BITS-1:WORD_BITS-1]) || !(|sh[PROD_BITS-1:WORD_BITS-1])) begin
      return sh[WORD_BITS-1:0];
    end
    return sh[PROD_BITS-1] ? WORD_MIN : WORD_MAX;
  endfunction

  logic [WORD_BITS-1:0]  inv_mass_r;
  word_t                 min_vel_r [AXES];
  word_t                 max_vel_r [AXES];
  kind_t                 kind_r;
  logic [STEP_BITS-1:0]  dt_r;
  word_t                 in_vec [AXES];
  word_t                 pos_nxt [AXES];
  word_t                 vel_nxt [AXES];

  assign in_vec[0] = in_item.vec_x;
  assign in_vec[1] = in_item.vec_y;
  assign in_vec[2] = in_item.vec_z;

  assign stat.in_update = (in_item.kind == KIND_UPDATE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r <= '0;
      for (int i = 0; i < AXES; i++) begin
        min_vel_r[i] <= '0;
        max_vel_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INV_MASS: inv_mass_r   <= cfg_wdata;
        CFG_MIN_X:    min_vel_r[0] <= cfg_wdata;
        CFG_MIN_Y:    min_vel_r[1] <= cfg_wdata;
        CFG_MIN_Z:    min_vel_r[2] <= cfg_wdata;
        CFG_MAX_X:    max_vel_r[0] <= cfg_wdata;
        CFG_MAX_Y:    max_vel_r[1] <= cfg_wdata;
        CFG_MAX_Z:    max_vel_r[2] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Capture kind and step time of the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_item.kind;
      dt_r   <= in_item.step_time;
    end
  end

  // One lane per axis, each with its own multiplier
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    word_t                       pos_r, vel_r, force_r;
    word_t                       force_nxt;
    word_t                       t_r;     // f = force + vec, or the value to set
    word_t                       v_r;     // new velocity before clamping
    logic signed [PROD_BITS-1:0] prod_r;
    logic signed [WORD_BITS-1:0] mul_a;
    logic signed [WORD_BITS:0]   mul_b;
    logic signed [PROD_BITS-1:0] prod_nxt;
    word_t                       v_clamp;

    // Select multiplier operands by step
    always_comb begin
      if (cmd.mul_acc) begin
        mul_a = t_r;
        mul_b = {1'b0, inv_mass_r};
      end else if (cmd.mul_dv) begin
        mul_a = sat_prod(prod_r);
        mul_b = {{(WORD_BITS+1-STEP_BITS){1'b0}}, dt_r};
      end else begin
        mul_a = v_r;
        mul_b = {{(WORD_BITS+1-STEP_BITS){1'b0}}, dt_r};
      end
    end

    assign prod_nxt = mul_a * mul_b;

    // Clamp to min first, then max so max wins
    always_comb begin
      v_clamp = v_r;
      if (v_clamp < min_vel_r[g]) begin
        v_clamp = min_vel_r[g];
      end
      if (v_clamp > max_vel_r[g]) begin
        v_clamp = max_vel_r[g];
      end
    end

    // Values written to the stores at commit
    always_comb begin
      pos_nxt[g] = pos_r;
      vel_nxt[g] = vel_r;
      force_nxt  = force_r;
      case (kind_r)
        KIND_ADD_FORCE: force_nxt = t_r;
        KIND_UPDATE: begin
          pos_nxt[g] = sat_add(pos_r, sat_prod(prod_r));
          vel_nxt[g] = v_clamp;
          force_nxt  = '0;
        end
        KIND_SET_POS: pos_nxt[g] = t_r;
        KIND_SET_VEL: vel_nxt[g] = t_r;
        default: begin
        end
      endcase
    end

    // Working registers
    always_ff @(posedge clk) begin
      if (cmd.load) begin
        if (in_item.kind inside {KIND_ADD_FORCE, KIND_UPDATE}) begin
          t_r <= sat_add(force_r, in_vec[g]);
        end else begin
          t_r <= in_vec[g];
        end
      end
      if (cmd.mul_acc || cmd.mul_dv || cmd.mul_dp) begin
        prod_r <= prod_nxt;
      end
      if (cmd.add_v) begin
        v_r <= sat_add(vel_r, sat_prod(prod_r));
      end
    end

    // Particle state
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r   <= '0;
        vel_r   <= '0;
        force_r <= '0;
      end else if (cmd.commit) begin
        pos_r   <= pos_nxt[g];
        vel_r   <= vel_nxt[g];
        force_r <= force_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.pos_x <= pos_nxt[0];
      out_item.pos_y <= pos_nxt[1];
      out_item.pos_z <= pos_nxt[2];
      out_item.vel_x <= vel_nxt[0];
      out_item.vel_y <= vel_nxt[1];
      out_item.vel_z <= vel_nxt[2];
    end
  end

endmodule

// File: design/particle_euler_integrator.sv
// Channel  | Signals                         | Beat
// ---------+---------------------------------+----------------------------------
// input    | in_valid / in_ready / in_item   | kind, vec_x/y/z, step_time
// result   | out_valid / out_ready / out_item| pos_x/y/z, vel_x/y/z
// config   | cfg_we / cfg_index / cfg_wdata  | one register write per cycle
//
// An update step runs through accept, four multiply/add steps through one 32x33
// multiplier per axis, and commit; add force and the two set kinds run through
// accept and commit only.
// Reset is synchronous, active low, and clears the stores and config registers.
// One result is held in an output register; while it waits the next beat is
// accepted and worked, and only the commit stalls until the register is free.
module particle_euler_integrator import pei_pkg::*; #(
  parameter int FRAC_BITS = PEI_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pei_in_t                 in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pei_out_t                out_item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_wdata
);

  pei_cmd_t  cmd;
  pei_stat_t stat;

  pei_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pei_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pei_pkg::*;

  // Shadow copy of the particle: registers, stores and the states it should report
  class particle_mirror;
    logic [31:0] inv_mass;
    word_t       vel_lo[AXES];
    word_t       vel_hi[AXES];
    word_t       pos[AXES];
    word_t       vel[AXES];
    word_t       force_acc[AXES];
    pei_out_t    expected_states[$];
    int          errors;

    function new();
      inv_mass = '0;
      errors = 0;
      for (int i = 0; i < AXES; i++) begin
        vel_lo[i] = '0;
        vel_hi[i] = '0;
        pos[i] = '0;
        vel[i] = '0;
        force_acc[i] = '0;
      end
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_INV_MASS: inv_mass = val;
        CFG_MIN_X:    vel_lo[0] = val;
        CFG_MIN_Y:    vel_lo[1] = val;
        CFG_MIN_Z:    vel_lo[2] = val;
        CFG_MAX_X:    vel_hi[0] = val;
        CFG_MAX_Y:    vel_hi[1] = val;
        CFG_MAX_Z:    vel_hi[2] = val;
        default: ;
      endcase
    endfunction

    // Signed sum clipped to the word range
    static function word_t add_clip(word_t a, word_t b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(WORD_MAX)) return WORD_MAX;
      if (s < longint'(WORD_MIN)) return WORD_MIN;
      return word_t'(s);
    endfunction

    // floor(a * b / 2^frac), clipped to the word range
    static function word_t mul_floor(word_t a, logic [32:0] b);
      logic signed [97:0] ax, bx, p;
      ax = a;
      bx = $signed({65'd0, b});
      p = (ax * bx) >>> PEI_FRAC_BITS;
      if (p[97:31] != {67{p[97]}}) return p[97] ? WORD_MIN : WORD_MAX;
      return p[31:0];
    endfunction

    // Advance the particle by one input beat and queue the state it should report
    function void accept_beat(pei_in_t it);
      word_t       v[AXES];
      word_t       acc, nv;
      logic [32:0] dt;
      pei_out_t    st;
      v[0] = it.vec_x;
      v[1] = it.vec_y;
      v[2] = it.vec_z;
      dt = {16'd0, it.step_time};
      for (int i = 0; i < AXES; i++) begin
        case (it.kind)
          KIND_ADD_FORCE: force_acc[i] = add_clip(force_acc[i], v[i]);
          KIND_SET_POS:   pos[i] = v[i];
          KIND_SET_VEL:   vel[i] = v[i];
          default: begin
            acc = mul_floor(add_clip(force_acc[i], v[i]), {1'b0, inv_mass});
            nv = add_clip(vel[i], mul_floor(acc, dt));
            pos[i] = add_clip(pos[i], mul_floor(nv, dt));
            // min clamp first, max clamp last so max wins when they cross
            if (nv < vel_lo[i]) nv = vel_lo[i];
            if (nv > vel_hi[i]) nv = vel_hi[i];
            vel[i] = nv;
            force_acc[i] = '0;
          end
        endcase
      end
      st.pos_x = pos[0];
      st.pos_y = pos[1];
      st.pos_z = pos[2];
      st.vel_x = vel[0];
      st.vel_y = vel[1];
      st.vel_z = vel[2];
      expected_states.push_back(st);
    endfunction

    function void compare_field(string name, word_t want, word_t got);
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // Compare a result beat with the oldest queued state
    function void check_beat(pei_out_t got);
      pei_out_t want;
      if (expected_states.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing queued: %h", got);
        return;
      end
      want = expected_states.pop_front();
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("pos_z", want.pos_z, got.pos_z);
      compare_field("vel_x", want.vel_x, got.vel_x);
      compare_field("vel_y", want.vel_y, got.vel_y);
      compare_field("vel_z", want.vel_z, got.vel_z);
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  pei_in_t                 in_item;
  logic                    out_valid;
  logic                    out_ready;
  pei_out_t                out_item;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WORD_BITS-1:0]    cfg_wdata;

  particle_mirror mirror;
  logic           steady;
  int             cycles = 0;

  particle_euler_integrator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Check result beats and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) mirror.check_beat(out_item);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  function automatic pei_in_t beat(kind_t k, word_t x, word_t y, word_t z,
                                   logic [STEP_BITS-1:0] dt);
    pei_in_t b;
    b.kind = k;
    b.vec_x = x;
    b.vec_y = y;
    b.vec_z = z;
    b.step_time = dt;
    return b;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
    endcase
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'h10000;
      2: return STEP_BITS'($urandom_range(0, 17'h1FFFF));
      default: return STEP_BITS'($urandom_range(1, 17'h10000));
    endcase
  endfunction

  function automatic pei_in_t pick_beat();
    int    r;
    kind_t k;
    r = $urandom_range(0, 99);
    if (r < 35) k = KIND_ADD_FORCE;
    else if (r < 75) k = KIND_UPDATE;
    else if (r < 88) k = KIND_SET_POS;
    else k = KIND_SET_VEL;
    return beat(k, pick_word(), pick_word(), pick_word(), pick_step());
  endfunction

  // Present one beat, idling first at random, and hold it until accepted
  task automatic send_beat(input pei_in_t it);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.accept_beat(it);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_beat(pick_beat());
  endtask

  // Drop valid and wait for every queued state to come back
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.expected_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    mirror.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [31:0] inv, input word_t lo_x, input word_t lo_y,
                            input word_t lo_z, input word_t hi_x, input word_t hi_y,
                            input word_t hi_z);
    put_reg(CFG_INV_MASS, inv);
    put_reg(CFG_MIN_X, lo_x);
    put_reg(CFG_MIN_Y, lo_y);
    put_reg(CFG_MIN_Z, lo_z);
    put_reg(CFG_MAX_X, hi_x);
    put_reg(CFG_MAX_Y, hi_y);
    put_reg(CFG_MAX_Z, hi_z);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Extremes, every kind, ignored step time, saturating sums and long steps
  task automatic send_directed();
    send_beat(beat(KIND_SET_POS, WORD_MAX, WORD_MIN, '0, 17'h1FFFF));
    send_beat(beat(KIND_SET_VEL, WORD_MIN, WORD_MAX, 32'sh10000, 17'h15555));
    send_beat(beat(KIND_UPDATE, '0, '0, '0, '0));
    send_beat(beat(KIND_UPDATE, '0, '0, '0, 17'h10000));
    send_beat(beat(KIND_SET_POS, '0, '0, '0, '0));
    send_beat(beat(KIND_SET_VEL, '0, '0, '0, 17'h0AAAA));
    send_beat(beat(KIND_ADD_FORCE, WORD_MAX, WORD_MIN, 32'sh10000, 17'h1FFFF));
    send_beat(beat(KIND_ADD_FORCE, WORD_MAX, WORD_MIN, 32'sh10000, '0));
    send_beat(beat(KIND_UPDATE, 32'sh10000, -32'sh10000, -32'sh8000, 17'h08000));
    send_beat(beat(KIND_ADD_FORCE, 32'sh1, -32'sh1, 32'sh7FFF, 17'h12345));
    send_beat(beat(KIND_UPDATE, -32'sh1, 32'sh1, '0, 17'h1FFFF));
    send_beat(beat(KIND_UPDATE, WORD_MAX, WORD_MIN, 32'sh12345678, 17'h10000));
    send_beat(beat(KIND_UPDATE, 32'sh3000, -32'sh3000, 32'sh1, 17'h00001));
    send_beat(beat(KIND_SET_VEL, 32'sh20000, -32'sh20000, '0, 17'h1FFFF));
    send_beat(beat(KIND_SET_POS, 32'sh10000, -32'sh10000, WORD_MAX, '0));
    send_beat(beat(KIND_UPDATE, '0, '0, '0, 17'h10000));
    send_beat(beat(KIND_UPDATE, '0, '0, '0, 17'h18000));
    send_beat(beat(KIND_ADD_FORCE, WORD_MIN, WORD_MAX, WORD_MIN, '0));
    send_beat(beat(KIND_UPDATE, WORD_MIN, WORD_MAX, WORD_MIN, 17'h10000));
  endtask

  initial begin
    word_t lo_d, hi_d;
    mirror = new();
    steady <= 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unit mass, no effective clamp
    set_config(32'h10000, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
    send_directed();
    send_random(80);
    settle();

    // Zero inverse mass, tight clamps
    set_config('0, -32'sh30000, -32'sh8000, '0, 32'sh50000, 32'sh8000, '0);
    send_random(90);
    settle();

    // Largest inverse mass, min above max; no idling on either side
    steady <= 1'b1;
    set_config(32'hFFFF_FFFF, WORD_MAX, WORD_MAX, 32'sh10000, WORD_MIN, WORD_MIN, -32'sh10000);
    send_random(90);
    settle();
    steady <= 1'b0;

    // Moderate random mass and random clamps spanning zero
    lo_d = $urandom_range(0, 32'h80000);
    hi_d = $urandom_range(0, 32'h80000);
    set_config($urandom_range(0, 32'h40000), -lo_d, -hi_d, -lo_d, hi_d, lo_d, hi_d);
    send_random(90);
    settle();

    // Anything goes
    set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_random(90);
    settle();

    if (mirror.errors == 0 && mirror.expected_states.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
